>>> src/hec_pkg.sv
// Package for the Hamming single-error-correcting coder.
// Holds widths, the config and result structs, and the position and parity functions.
// No dependencies.
package hec_pkg;

    localparam int unsigned MAX_PARITY     = 6;
    localparam int unsigned DATA_W         = 57;
    localparam int unsigned CODE_W         = 63;
    localparam int unsigned LEN_W          = 6;
    localparam int unsigned MIN_DATA       = 1;
    localparam int unsigned MAX_DATA       = 57;
    localparam int unsigned RESET_DATA_LEN = 4;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    // Settings derived from the data length register
    typedef struct packed {
        logic [LEN_W-1:0]  len;   // codeword length in bits
        logic [CODE_W-1:0] mask;  // ones over the valid codeword positions
    } t_cfg;

    // One result item
    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
        logic [LEN_W-1:0]  syndrome;
        logic              error_found;
        logic [LEN_W-1:0]  error_index;
        logic              uncorrectable;
    } t_result;

    // Place data bits at the positions that are not powers of two (pure wiring)
    function automatic logic [CODE_W-1:0] spread(input logic [DATA_W-1:0] data);
        logic [CODE_W-1:0] w;
        int unsigned       idx;
        w   = '0;
        idx = 0;
        for (int unsigned p = 1; p <= CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                w[p-1] = data[idx];
                idx++;
            end
        end
        return w;
    endfunction

    // Positions (1-based) that parity bit k covers
    function automatic logic [CODE_W-1:0] group_mask(input int unsigned k);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int unsigned p = 1; p <= CODE_W; p++) begin
            m[p-1] = ((p >> k) & 1) != 0;
        end
        return m;
    endfunction

    // Even-parity syndrome: one XOR tree per parity group
    function automatic logic [LEN_W-1:0] syndrome(input logic [CODE_W-1:0] word);
        logic [LEN_W-1:0] s;
        s = '0;
        for (int unsigned k = 0; k < MAX_PARITY; k++) begin
            s[k] = ^(word & group_mask(k));
        end
        return s;
    endfunction

    // Codeword length for a raw register value; out-of-range lengths clamp
    function automatic logic [LEN_W-1:0] code_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] nd;
        logic [2:0]       r;
        nd = raw;
        if (nd < LEN_W'(MIN_DATA)) begin
            nd = LEN_W'(MIN_DATA);
        end
        if (nd > LEN_W'(MAX_DATA)) begin
            nd = LEN_W'(MAX_DATA);
        end
        // smallest r with 2**r >= nd + r + 1
        if (nd <= 6'd1) begin
            r = 3'd2;
        end else if (nd <= 6'd4) begin
            r = 3'd3;
        end else if (nd <= 6'd11) begin
            r = 3'd4;
        end else if (nd <= 6'd26) begin
            r = 3'd5;
        end else begin
            r = 3'd6;
        end
        return nd + {3'b000, r};
    endfunction

    // Ones below len
    function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] m;
        for (int unsigned b = 0; b < CODE_W; b++) begin
            m[b] = LEN_W'(b) < len;
        end
        return m;
    endfunction

endpackage

>>> src/hamming_encode_correct.sv
// Top level of the Hamming single-error-correcting coder.
// Input register, hec_core datapath, result register; hec_cfg holds the data length.
// Depends on hec_pkg, hec_cfg, hec_core.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------------------
//   input   | in        | i_in_valid / o_in_stall   | i_op, i_data_bits, i_received_word
//   result  | out       | o_out_valid / i_out_stall | o_code_word .. o_uncorrectable
//   config  | in        | i_cfg_we                  | i_cfg_wdata (data length)
//
// An item passes the input register, then the result register, where its result is valid;
// one item per cycle sustained while the result side does not stall.
// The stage is one pass of XOR trees (syndrome) between input and result registers.
// Reset (synchronous, i_rst_n low) empties both stages and sets data length to 4.
// A stall on the result side holds the result register; the input register
// keeps filling until it too is full, then o_in_stall rises.
module hamming_encode_correct (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config
    input  logic                        i_cfg_we,
    input  logic [hec_pkg::LEN_W-1:0]   i_cfg_wdata,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic [hec_pkg::DATA_W-1:0]  i_data_bits,
    input  logic [hec_pkg::CODE_W-1:0]  i_received_word,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [hec_pkg::CODE_W-1:0]  o_code_word,
    output logic [hec_pkg::LEN_W-1:0]   o_code_length,
    output logic [hec_pkg::LEN_W-1:0]   o_syndrome,
    output logic                        o_error_found,
    output logic [hec_pkg::LEN_W-1:0]   o_error_index,
    output logic                        o_uncorrectable
);

    hec_pkg::t_cfg              w_cfg;
    hec_pkg::t_result           n_res;
    hec_pkg::t_result           r_res;
    logic                       r_v1;
    logic                       r_v2;
    hec_pkg::t_op               r_op;
    logic [hec_pkg::DATA_W-1:0] r_data;
    logic [hec_pkg::CODE_W-1:0] r_recv;
    logic                       w_s2_load;
    logic                       w_s1_load;

    hec_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    hec_core u_core (
        .i_op            (r_op),
        .i_data_bits     (r_data),
        .i_received_word (r_recv),
        .i_cfg           (w_cfg),
        .o_result        (n_res)
    );

    // Stage advance: each register loads when it is empty or its content moves on
    assign w_s2_load  = !r_v2 || !i_out_stall;
    assign w_s1_load  = !r_v1 || w_s2_load;
    assign o_in_stall = !w_s1_load;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_s1_load) begin
            r_v1 <= i_in_valid;
        end
        if (w_s1_load && i_in_valid) begin
            r_op   <= hec_pkg::t_op'(i_op);
            r_data <= i_data_bits;
            r_recv <= i_received_word;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_s2_load) begin
            r_v2 <= r_v1;
        end
        if (w_s2_load && r_v1) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_v2;
    assign o_code_word     = r_res.code_word;
    assign o_code_length   = r_res.code_length;
    assign o_syndrome      = r_res.syndrome;
    assign o_error_found   = r_res.error_found;
    assign o_error_index   = r_res.error_index;
    assign o_uncorrectable = r_res.uncorrectable;

`ifndef SYNTH
    // An uncorrectable word always has a nonzero syndrome
    a_bad_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_uncorrectable |-> o_error_found)
        else $error("uncorrectable without error_found");

    // No error means nothing flipped and a zero syndrome
    a_clean_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_error_found |-> o_syndrome == '0 && o_error_index == '0)
        else $error("clean result with nonzero syndrome or index");

    // A held input item stays in place until the result stage takes it
    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !w_s2_load |=> r_v1 && $stable(r_recv) && $stable(r_data))
        else $error("input register lost an item under stall");

    // Input stall only when both stages are full and the result side stalls
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_v1 && r_v2 && i_out_stall)
        else $error("input stalled without a full pipeline");

    // Codeword length is never below three bits
    a_len_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg.len >= 6'd3)
        else $error("codeword length below minimum");
`endif

endmodule

>>> src/hec_cfg.sv
// Data length register for the Hamming coder.
// Turns a written data length into codeword length and position mask.
// Depends on hec_pkg.
module hec_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hec_pkg::LEN_W-1:0]   i_cfg_wdata,
    output hec_pkg::t_cfg               o_cfg
);

    hec_pkg::t_cfg    r_cfg;
    hec_pkg::t_cfg    n_cfg;
    logic [hec_pkg::LEN_W-1:0] w_len;

    // Derive length and mask at write time
    always_comb begin
        w_len      = hec_pkg::code_len(i_cfg_wdata);
        n_cfg.len  = w_len;
        n_cfg.mask = hec_pkg::len_mask(w_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.len  <= hec_pkg::code_len(hec_pkg::LEN_W'(hec_pkg::RESET_DATA_LEN));
            r_cfg.mask <= hec_pkg::len_mask(
                hec_pkg::code_len(hec_pkg::LEN_W'(hec_pkg::RESET_DATA_LEN)));
        end else if (i_cfg_we) begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/hec_core.sv
// Encode / check-and-correct datapath of the Hamming coder.
// Combinational: spreads data, builds syndrome, sets parity or flips the named bit or flags it uncorrectable.
// Depends on hec_pkg.
module hec_core (
    input  hec_pkg::t_op                 i_op,
    input  logic [hec_pkg::DATA_W-1:0]   i_data_bits,
    input  logic [hec_pkg::CODE_W-1:0]   i_received_word,
    input  hec_pkg::t_cfg                i_cfg,
    output hec_pkg::t_result             o_result
);

    logic [hec_pkg::CODE_W-1:0] w_word;
    logic [hec_pkg::LEN_W-1:0]  w_syn;
    logic [hec_pkg::CODE_W-1:0] w_par;

    // Word to check: spread data in encode mode, received word otherwise
    always_comb begin
        if (i_op == hec_pkg::OP_ENCODE) begin
            w_word = hec_pkg::spread(i_data_bits) & i_cfg.mask;
        end else begin
            w_word = i_received_word & i_cfg.mask;
        end
        w_syn = hec_pkg::syndrome(w_word);
    end

    // Parity bits land at positions 2**k; unused groups come out zero
    always_comb begin
        w_par = '0;
        for (int unsigned k = 0; k < hec_pkg::MAX_PARITY; k++) begin
            w_par[(1 << k) - 1] = w_syn[k];
        end
    end

    // Result assembly
    always_comb begin
        o_result               = '0;
        o_result.code_length   = i_cfg.len;
        if (i_op == hec_pkg::OP_ENCODE) begin
            o_result.code_word = w_word | w_par;
        end else begin
            o_result.code_word   = w_word;
            o_result.syndrome    = w_syn;
            o_result.error_found = w_syn != '0;
            if (w_syn > i_cfg.len) begin
                o_result.uncorrectable = 1'b1;
            end else if (w_syn != '0) begin
                o_result.error_index = w_syn - hec_pkg::LEN_W'(1);
                o_result.code_word   = w_word ^ (hec_pkg::CODE_W'(1) << (w_syn - 6'd1));
            end
        end
    end

endmodule
